[design/fir_pkg.sv]
// ----------------------------------------------------------------------------
// fir_pkg
// Shared types and codes of the fault-injection registry: request modes,
// status codes and the layout of one fault table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package fir_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned MOD_W    = 4;
  localparam int unsigned OBJ_W    = 8;
  localparam int unsigned FID_W    = 8;
  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NUM_IDS  = 16;

  localparam logic [MODE_W-1:0] MODE_REG_MODULE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REG_FAULT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ENABLE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DISABLE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY_TYPE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY_OBJ  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REG_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH   = 2'd3;

  localparam logic [TYPE_W-1:0] NO_FAULT = 2'd3;

  typedef struct packed {
    logic [MOD_W-1:0]  module_id;
    logic [OBJ_W-1:0]  object_id;
    logic [FID_W-1:0]  fault_id;
    logic [TYPE_W-1:0] fault_type;
    logic              enabled;
  } entry_t;

endpackage

`default_nettype wire

[design/fault_injection_registry.sv]
// ----------------------------------------------------------------------------
// fault_injection_registry
// Fault table in one synchronous memory, scanned entry by entry for enable,
// disable and queries, with per-module injected flags.
//
//   channel | ports                        | handshake
//   --------+------------------------------+------------------------------
//   request | in_mode .. in_fault_type     | start high while busy low
//   result  | out_status .. out_module_inj | out_valid, one cycle strobe
//
// Register module, register fault and unused modes answer in the cycle after
// the beat. Enable, disable and queries scan the table through the memory
// read port, one entry per cycle; a query stops at its first hit; an empty
// table answers in the cycle after the beat.
// busy is high during the scan. Synchronous active-low reset clears counts
// and flags; table entries are only used below the fill count.
// The receiver cannot stall: each result beat shows for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_injection_registry #(
  parameter int unsigned MAX_FAULTS  = 64,
  parameter int unsigned MAX_MODULES = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire  [fir_pkg::MODE_W-1:0]     in_mode,
  input  wire  [fir_pkg::MOD_W-1:0]      in_module_id,
  input  wire  [fir_pkg::OBJ_W-1:0]      in_object_id,
  input  wire  [fir_pkg::FID_W-1:0]      in_fault_id,
  input  wire  [fir_pkg::TYPE_W-1:0]     in_fault_type,
  output logic                           out_valid,
  output logic [fir_pkg::STATUS_W-1:0]   out_status,
  output logic [fir_pkg::TYPE_W-1:0]     out_found_type,
  output logic [fir_pkg::MOD_W-1:0]      out_assigned_module,
  output logic                           out_module_injected
);

  import fir_pkg::*;

  localparam int unsigned AW  = (MAX_FAULTS > 1) ? $clog2(MAX_FAULTS) : 1;
  localparam int unsigned FCW = $clog2(MAX_FAULTS + 1);
  localparam int unsigned MCW = $clog2(MAX_MODULES + 1);
  localparam int unsigned MXW = MCW + MOD_W;

  typedef enum logic [0:0] {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state_r;

  entry_t            table_mem [MAX_FAULTS];
  logic [$bits(entry_t)-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;

  logic [FCW-1:0]    fault_cnt_r;
  logic [MCW-1:0]    mod_cnt_r;
  logic [NUM_IDS-1:0] flags_r;

  logic [MODE_W-1:0] req_mode_r;
  logic [MOD_W-1:0]  req_mod_r;
  logic [OBJ_W-1:0]  req_obj_r;
  logic [FID_W-1:0]  req_fid_r;
  logic [AW-1:0]     idx_r;
  logic              hit_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TYPE_W-1:0]   out_found_r;
  logic [MOD_W-1:0]    out_assigned_r;
  logic                out_inj_r;

  entry_t         ent;
  logic           id_hit;
  logic           obj_hit;
  logic           sel_hit;
  logic           is_query;
  logic           is_update;
  logic           last;
  logic           known;
  logic           any_hit;
  logic [MXW-1:0] mc_ext;
  logic           in_scan_mode;
  logic           table_full;

  assign ent       = entry_t'(rd_data_r);
  assign id_hit    = (ent.module_id == req_mod_r) && (ent.object_id == req_obj_r) &&
                     (ent.fault_id == req_fid_r);
  assign obj_hit   = (ent.module_id == req_mod_r) && (ent.object_id == req_obj_r) &&
                     ent.enabled;
  assign is_query  = (req_mode_r == MODE_QUERY_TYPE) || (req_mode_r == MODE_QUERY_OBJ);
  assign is_update = (req_mode_r == MODE_ENABLE) || (req_mode_r == MODE_DISABLE);
  assign sel_hit   = (req_mode_r == MODE_QUERY_OBJ) ? obj_hit : id_hit;
  assign last      = ((FCW'(idx_r) + FCW'(1)) == fault_cnt_r);
  assign mc_ext    = MXW'(mod_cnt_r);
  assign known     = (MXW'(req_mod_r) < mc_ext);
  assign any_hit   = hit_r || id_hit;
  assign table_full = (fault_cnt_r >= FCW'(MAX_FAULTS));
  assign in_scan_mode = (in_mode == MODE_ENABLE) || (in_mode == MODE_DISABLE) ||
                        (in_mode == MODE_QUERY_TYPE) || (in_mode == MODE_QUERY_OBJ);

  // read address: entry 0 on the beat, then one ahead of the scan index
  assign rd_addr = (state_r == S_IDLE) ? '0 : AW'(idx_r + AW'(1));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = ent;
    if (state_r == S_IDLE) begin
      if (start && (in_mode == MODE_REG_FAULT) && !table_full) begin
        wr_en              = 1'b1;
        wr_addr            = fault_cnt_r[AW-1:0];
        wr_data.module_id  = in_module_id;
        wr_data.object_id  = in_object_id;
        wr_data.fault_id   = in_fault_id;
        wr_data.fault_type = in_fault_type;
        wr_data.enabled    = 1'b0;
      end
    end else if (is_update && id_hit) begin
      wr_en           = 1'b1;
      wr_data.enabled = (req_mode_r == MODE_ENABLE);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fault_cnt_r <= '0;
      mod_cnt_r   <= '0;
      flags_r     <= '0;
      hit_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_mode_r <= in_mode;
            req_mod_r  <= in_module_id;
            req_obj_r  <= in_object_id;
            req_fid_r  <= in_fault_id;
            idx_r      <= '0;
            hit_r      <= 1'b0;
            if (in_scan_mode && (fault_cnt_r != '0)) begin
              state_r <= S_SCAN;
            end else begin
              out_valid_r    <= 1'b1;
              out_status_r   <= ST_OK;
              out_found_r    <= NO_FAULT;
              out_assigned_r <= '0;
              out_inj_r      <= flags_r[in_module_id];
              unique case (in_mode)
                MODE_REG_MODULE: begin
                  if (mod_cnt_r >= MCW'(MAX_MODULES)) begin
                    out_status_r <= ST_REG_FULL;
                  end else begin
                    out_assigned_r <= mc_ext[MOD_W-1:0];
                    mod_cnt_r      <= mod_cnt_r + MCW'(1);
                  end
                end
                MODE_REG_FAULT: begin
                  if (table_full) begin
                    out_status_r <= ST_TABLE_FULL;
                  end else begin
                    fault_cnt_r <= fault_cnt_r + FCW'(1);
                  end
                end
                MODE_ENABLE, MODE_DISABLE, MODE_QUERY_TYPE, MODE_QUERY_OBJ: begin
                  out_status_r <= ST_NO_MATCH;
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_SCAN: begin
          if (sel_hit) begin
            hit_r <= 1'b1;
          end
          if (is_query && sel_hit) begin
            state_r        <= S_IDLE;
            out_valid_r    <= 1'b1;
            out_status_r   <= ST_OK;
            out_found_r    <= ent.fault_type;
            out_assigned_r <= '0;
            out_inj_r      <= flags_r[req_mod_r];
          end else if (last) begin
            state_r        <= S_IDLE;
            out_valid_r    <= 1'b1;
            out_found_r    <= NO_FAULT;
            out_assigned_r <= '0;
            if (is_update && any_hit) begin
              out_status_r <= ST_OK;
              if (known) begin
                flags_r[req_mod_r] <= (req_mode_r == MODE_ENABLE);
                out_inj_r          <= (req_mode_r == MODE_ENABLE);
              end else begin
                out_inj_r <= flags_r[req_mod_r];
              end
            end else begin
              out_status_r <= ST_NO_MATCH;
              out_inj_r    <= flags_r[req_mod_r];
            end
          end else begin
            idx_r <= AW'(idx_r + AW'(1));
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_found_type      = out_found_r;
  assign out_assigned_module = out_assigned_r;
  assign out_module_injected = out_inj_r;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fault-injection registry. A short directed run
// covers the empty table, the spare modes, unregistered modules, duplicates
// and enable/disable/query round trips. A long random run follows: requests
// are biased toward ids already in the table, and it sends RANDOM_BEATS
// requests. A scoreboard predicts every result beat and compares it field
// by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fir_pkg::*;

  localparam int unsigned MAX_FAULTS   = 64;
  localparam int unsigned MAX_MODULES  = 16;
  localparam int unsigned RANDOM_BEATS = 1230;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 80;

  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TYPE_W-1:0]   found_type;
    logic [MOD_W-1:0]    assigned_module;
    logic                module_injected;
  } answer_t;

  class registry_scoreboard;
    entry_t      fault_tab[MAX_FAULTS];
    int unsigned fault_cnt;
    int unsigned module_cnt;
    bit          injected[MAX_MODULES];
    answer_t     answer_q[$];
    int unsigned mismatches;

    function new();
      fault_cnt  = 0;
      module_cnt = 0;
      mismatches = 0;
      foreach (injected[m]) injected[m] = 1'b0;
    endfunction

    function bit module_known(logic [MOD_W-1:0] mod);
      return mod < module_cnt && mod < MAX_MODULES;
    endfunction

    function bit ids_match(entry_t e, logic [MOD_W-1:0] mod, logic [OBJ_W-1:0] obj,
                           logic [FID_W-1:0] fid);
      return e.module_id == mod && e.object_id == obj && e.fault_id == fid;
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [MOD_W-1:0] mod,
                               logic [OBJ_W-1:0] obj, logic [FID_W-1:0] fid,
                               logic [TYPE_W-1:0] ftype);
      answer_t a;
      bit      hit;
      bit      sel;
      a = '{status: ST_OK, found_type: NO_FAULT, assigned_module: '0, module_injected: 1'b0};
      hit = 1'b0;
      case (mode)
        MODE_REG_MODULE: begin
          if (module_cnt >= MAX_MODULES) begin
            a.status = ST_REG_FULL;
          end else begin
            a.assigned_module = MOD_W'(module_cnt);
            module_cnt++;
          end
        end
        MODE_REG_FAULT: begin
          if (fault_cnt >= MAX_FAULTS) begin
            a.status = ST_TABLE_FULL;
          end else begin
            fault_tab[fault_cnt] = '{module_id: mod, object_id: obj, fault_id: fid,
                                     fault_type: ftype, enabled: 1'b0};
            fault_cnt++;
          end
        end
        MODE_ENABLE, MODE_DISABLE: begin
          for (int i = 0; i < fault_cnt; i++) begin
            if (ids_match(fault_tab[i], mod, obj, fid)) begin
              fault_tab[i].enabled = (mode == MODE_ENABLE);
              hit = 1'b1;
            end
          end
          if (!hit) begin
            a.status = ST_NO_MATCH;
          end else if (module_known(mod)) begin
            injected[mod] = (mode == MODE_ENABLE);
          end
        end
        MODE_QUERY_TYPE, MODE_QUERY_OBJ: begin
          for (int i = 0; i < fault_cnt && !hit; i++) begin
            if (mode == MODE_QUERY_TYPE) begin
              sel = ids_match(fault_tab[i], mod, obj, fid);
            end else begin
              sel = fault_tab[i].module_id == mod && fault_tab[i].object_id == obj &&
                    fault_tab[i].enabled;
            end
            if (sel) begin
              a.found_type = fault_tab[i].fault_type;
              hit = 1'b1;
            end
          end
          if (!hit) a.status = ST_NO_MATCH;
        end
        default: ;
      endcase
      a.module_injected = module_known(mod) && injected[mod];
      answer_q = {answer_q, a};
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(answer_t got);
      answer_t want;
      if (answer_q.size() == 0) begin
        report($sformatf("result beat with nothing pending (status %0d)", got.status));
        return;
      end
      want = answer_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.found_type !== want.found_type)
        report($sformatf("found_type %0d, predicted %0d", got.found_type, want.found_type));
      if (got.assigned_module !== want.assigned_module)
        report($sformatf("assigned_module %0d, predicted %0d", got.assigned_module,
                         want.assigned_module));
      if (got.module_injected !== want.module_injected)
        report($sformatf("module_injected %0b, predicted %0b", got.module_injected,
                         want.module_injected));
    endtask
  endclass

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic [MODE_W-1:0]   in_mode       = '0;
  logic [MOD_W-1:0]    in_module_id  = '0;
  logic [OBJ_W-1:0]    in_object_id  = '0;
  logic [FID_W-1:0]    in_fault_id   = '0;
  logic [TYPE_W-1:0]   in_fault_type = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [TYPE_W-1:0]   out_found_type;
  logic [MOD_W-1:0]    out_assigned_module;
  logic                out_module_injected;

  registry_scoreboard sb = new();
  int unsigned        stall_cycles = 0;

  always #6 clk = ~clk;

  fault_injection_registry #(
    .MAX_FAULTS (MAX_FAULTS),
    .MAX_MODULES(MAX_MODULES)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_module_id       (in_module_id),
    .in_object_id       (in_object_id),
    .in_fault_id        (in_fault_id),
    .in_fault_type      (in_fault_type),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_type     (out_found_type),
    .out_assigned_module(out_assigned_module),
    .out_module_injected(out_module_injected)
  );

  // result beat is checked before the request beat of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result('{out_status, out_found_type, out_assigned_module,
                          out_module_injected});
      if (start && !busy)
        sb.note_request(in_mode, in_module_id, in_object_id, in_fault_id, in_fault_type);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("[fault_injection_registry] ERROR");
      $finish;
    end
  end

  task automatic send_request(input logic [MODE_W-1:0] mode, logic [MOD_W-1:0] mod,
                              logic [OBJ_W-1:0] obj, logic [FID_W-1:0] fid,
                              logic [TYPE_W-1:0] ftype);
    start         <= 1'b1;
    in_mode       <= mode;
    in_module_id  <= mod;
    in_object_id  <= obj;
    in_fault_id   <= fid;
    in_fault_type <= ftype;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    start         <= 1'b0;
    in_mode       <= MODE_W'($urandom);
    in_module_id  <= MOD_W'($urandom);
    in_object_id  <= OBJ_W'($urandom);
    in_fault_id   <= FID_W'($urandom);
    in_fault_type <= TYPE_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.answer_q.size() != 0);
  endtask

  task automatic send_random(input bit allow_gap);
    entry_t              e;
    int unsigned         pick;
    bit                  reuse;
    logic [MODE_W-1:0]   mode;
    logic [MOD_W-1:0]    mod;
    logic [OBJ_W-1:0]    obj;
    logic [FID_W-1:0]    fid;
    logic [TYPE_W-1:0]   ftype;
    pick  = $urandom_range(0, 99);
    mod   = MOD_W'($urandom);
    obj   = OBJ_W'($urandom);
    fid   = FID_W'($urandom);
    ftype = TYPE_W'($urandom);
    reuse = sb.fault_cnt != 0 && $urandom_range(0, 99) < 80;
    if (reuse) e = sb.fault_tab[$urandom_range(0, sb.fault_cnt - 1)];
    if (pick < 3) mode = MODE_REG_MODULE;
    else if (pick < 13) mode = MODE_REG_FAULT;
    else if (pick < 33) mode = MODE_ENABLE;
    else if (pick < 48) mode = MODE_DISABLE;
    else if (pick < 68) mode = MODE_QUERY_TYPE;
    else if (pick < 96) mode = MODE_QUERY_OBJ;
    else mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
    // aim at existing entries so matches, duplicates and shared objects occur
    if (reuse && (mode != MODE_REG_FAULT || $urandom_range(0, 1) == 0)) begin
      mod = e.module_id;
      obj = e.object_id;
      if ($urandom_range(0, 3) != 0) fid = e.fault_id;
    end
    if (allow_gap && $urandom_range(0, 99) < 19)
      idle_gap($urandom_range(0, 99) < 85 ? $urandom_range(1, 4) : $urandom_range(5, 70));
    send_request(mode, mod, obj, fid, ftype);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, spare modes and module registration
    send_request(MODE_QUERY_TYPE, 4'd0, 8'd0, 8'd0, 2'd0);
    send_request(MODE_QUERY_OBJ, 4'd15, 8'hff, 8'hff, 2'd3);
    send_request(MODE_ENABLE, 4'd0, 8'd0, 8'd0, 2'd0);
    send_request(MODE_DISABLE, 4'd15, 8'hff, 8'hff, 2'd3);
    send_request(MODE_SPARE_A, 4'd3, 8'h12, 8'h34, 2'd1);
    send_request(MODE_SPARE_B, 4'd15, 8'hff, 8'hff, 2'd3);
    send_request(MODE_REG_MODULE, 4'd9, 8'd0, 8'd0, 2'd0);
    send_request(MODE_REG_MODULE, 4'd0, 8'hff, 8'hff, 2'd3);
    // field extremes, a duplicate pair and an entry of an unregistered module
    send_request(MODE_REG_FAULT, 4'd0, 8'd0, 8'd0, 2'd0);
    send_request(MODE_REG_FAULT, 4'd15, 8'hff, 8'hff, 2'd3);
    send_request(MODE_REG_FAULT, 4'd1, 8'ha5, 8'h5a, 2'd2);
    send_request(MODE_REG_FAULT, 4'd1, 8'ha5, 8'h5a, 2'd1);
    send_request(MODE_QUERY_TYPE, 4'd1, 8'ha5, 8'h5a, 2'd0);
    send_request(MODE_QUERY_OBJ, 4'd1, 8'ha5, 8'h00, 2'd0);
    send_request(MODE_ENABLE, 4'd1, 8'ha5, 8'h5a, 2'd0);
    send_request(MODE_QUERY_OBJ, 4'd1, 8'ha5, 8'h77, 2'd0);
    send_request(MODE_ENABLE, 4'd15, 8'hff, 8'hff, 2'd0);
    send_request(MODE_QUERY_OBJ, 4'd15, 8'hff, 8'h00, 2'd0);
    send_request(MODE_DISABLE, 4'd1, 8'ha5, 8'h5a, 2'd0);
    send_request(MODE_QUERY_OBJ, 4'd1, 8'ha5, 8'h5a, 2'd0);
    send_request(MODE_DISABLE, 4'd0, 8'd0, 8'd0, 2'd0);
    send_request(MODE_ENABLE, 4'd0, 8'd0, 8'd1, 2'd0);
    drain();

    // no idling in the middle stretch, one full drain inside it
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 600) drain();
      send_random(n < 400 || n >= 750);
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("[fault_injection_registry] OK");
    end else begin
      $display("[fault_injection_registry] ERROR");
    end
    $finish;
  end

endmodule
